/* sv/sit_pkg.sv */
package sit_pkg;

	// quotient bits produced by the pipelined divider, one per stage
	localparam int DIV_QBITS = 32;
	// divider latency: abs, scale and range check, one stage per quotient bit, rounding
	localparam int DIV_LAT   = DIV_QBITS + 3;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	localparam logic [31:0] MEET_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] MEET_MIN = 32'h8000_0000;

	typedef struct packed {
		logic seg_cross;
		logic parallel;
	} flags_t;

endpackage

/* sv/sit_queue.sv */
module sit_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	logic [WIDTH-1:0]              mem_q [sit_pkg::Q_DEPTH];
	logic [sit_pkg::Q_AW-1:0]      wr_ptr_q;
	logic [sit_pkg::Q_AW-1:0]      rd_ptr_q;
	logic [sit_pkg::Q_CW-1:0]      cnt_q;

	assign full     = (cnt_q == sit_pkg::Q_CW'(sit_pkg::Q_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + sit_pkg::Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + sit_pkg::Q_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + sit_pkg::Q_CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - sit_pkg::Q_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* sv/sit_front.sv */
module sit_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic signed [COORD_BITS-1:0]  seg1_start_x,
	input  logic signed [COORD_BITS-1:0]  seg1_start_y,
	input  logic signed [COORD_BITS-1:0]  seg1_end_x,
	input  logic signed [COORD_BITS-1:0]  seg1_end_y,
	input  logic signed [COORD_BITS-1:0]  seg2_start_x,
	input  logic signed [COORD_BITS-1:0]  seg2_start_y,
	input  logic signed [COORD_BITS-1:0]  seg2_end_x,
	input  logic signed [COORD_BITS-1:0]  seg2_end_y,
	input  logic                          q_full,
	output logic                          q_push,
	output logic signed [3*COORD_BITS+3:0] num_x,
	output logic signed [3*COORD_BITS+3:0] num_y,
	output logic [2*COORD_BITS+1:0]       den,
	output sit_pkg::flags_t               flags
);

	localparam int CW  = COORD_BITS;
	localparam int DW1 = CW + 1;         // coordinate differences
	localparam int PW  = 2 * DW1;        // difference products
	localparam int XW  = 2 * CW + 3;     // cross, tn, un
	localparam int DW  = 2 * CW + 2;     // |cross|
	localparam int HW  = CW + 1;         // low split of |cross| and tn
	localparam int TH  = XW - HW;
	localparam int DH  = DW - HW;
	localparam int PSW = CW + HW + 1;    // start * split |cross|
	localparam int PDW = DW1 + HW + 1;   // dir * split tn
	localparam int NW  = 3 * CW + 4;

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	// s1: differences
	logic signed [CW-1:0]  p1x_s1, p1y_s1;
	logic signed [DW1-1:0] d1x_s1, d1y_s1, d2x_s1, d2y_s1, wx_s1, wy_s1;
	// s2: products
	logic signed [CW-1:0]  p1x_s2, p1y_s2;
	logic signed [DW1-1:0] d1x_s2, d1y_s2;
	logic signed [PW-1:0]  ma_s2, mb_s2, mc_s2, md_s2, me_s2, mf_s2;
	// s3: cross and numerators
	logic signed [CW-1:0]  p1x_s3, p1y_s3;
	logic signed [DW1-1:0] d1x_s3, d1y_s3;
	logic signed [XW-1:0]  cross_s3, tn_s3, un_s3;
	// s4: sign normalized, classified
	logic signed [CW-1:0]  p1x_s4, p1y_s4;
	logic signed [DW1-1:0] d1x_s4, d1y_s4;
	logic signed [XW-1:0]  tn_s4;
	logic [DW-1:0]         den_s4;
	sit_pkg::flags_t       flg_s4;
	// s5: partial products
	logic signed [PSW-1:0] psl_x_s5, psh_x_s5, psl_y_s5, psh_y_s5;
	logic signed [PDW-1:0] pdl_x_s5, pdh_x_s5, pdl_y_s5, pdh_y_s5;
	logic [DW-1:0]         den_s5;
	sit_pkg::flags_t       flg_s5;
	// s6: partial sums
	logic signed [NW-1:0]  a_x_s6, b_x_s6, a_y_s6, b_y_s6;
	logic [DW-1:0]         den_s6;
	sit_pkg::flags_t       flg_s6;
	// s7: numerators
	logic signed [NW-1:0]  num_x_s7, num_y_s7;
	logic [DW-1:0]         den_s7;
	sit_pkg::flags_t       flg_s7;

	// s4 combinational
	logic signed [XW-1:0]  cabs, tnn, unn;
	logic                  c_cross;
	// s5 combinational
	logic [HW-1:0]         dl, tl;
	logic [DH-1:0]         dh;
	logic signed [TH-1:0]  th;
	logic signed [PSW-1:0] psl_x, psh_x, psl_y, psh_y;
	logic signed [PDW-1:0] pdl_x, pdh_x, pdl_y, pdh_y;

	// whole pipe holds only when the last stage cannot hand off
	assign en         = !(vld_s7 && q_full);
	assign item_stall = !en;
	assign q_push     = vld_s7 && !q_full;
	assign num_x      = num_x_s7;
	assign num_y      = num_y_s7;
	assign den        = den_s7;
	assign flags      = flg_s7;

	always_comb begin
		cabs = cross_s3[XW-1] ? -cross_s3 : cross_s3;
		tnn  = cross_s3[XW-1] ? -tn_s3 : tn_s3;
		unn  = cross_s3[XW-1] ? -un_s3 : un_s3;
		c_cross = !tnn[XW-1] && (tnn <= cabs) && !unn[XW-1] && (unn <= cabs);
	end

	always_comb begin
		dl = den_s4[HW-1:0];
		dh = den_s4[DW-1:HW];
		tl = tn_s4[HW-1:0];
		th = $signed(tn_s4[XW-1:HW]);
	end

	// start*|cross| and dir*tn, operands split so each multiply stays narrow
	assign psl_x = p1x_s4 * $signed({1'b0, dl});
	assign psh_x = p1x_s4 * $signed({1'b0, dh});
	assign psl_y = p1y_s4 * $signed({1'b0, dl});
	assign psh_y = p1y_s4 * $signed({1'b0, dh});
	assign pdl_x = d1x_s4 * $signed({1'b0, tl});
	assign pdh_x = d1x_s4 * th;
	assign pdl_y = d1y_s4 * $signed({1'b0, tl});
	assign pdh_y = d1y_s4 * th;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= item_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1x_s1 <= seg1_start_x;
			p1y_s1 <= seg1_start_y;
			d1x_s1 <= $signed({seg1_end_x[CW-1], seg1_end_x})
				- $signed({seg1_start_x[CW-1], seg1_start_x});
			d1y_s1 <= $signed({seg1_end_y[CW-1], seg1_end_y})
				- $signed({seg1_start_y[CW-1], seg1_start_y});
			d2x_s1 <= $signed({seg2_end_x[CW-1], seg2_end_x})
				- $signed({seg2_start_x[CW-1], seg2_start_x});
			d2y_s1 <= $signed({seg2_end_y[CW-1], seg2_end_y})
				- $signed({seg2_start_y[CW-1], seg2_start_y});
			wx_s1  <= $signed({seg2_start_x[CW-1], seg2_start_x})
				- $signed({seg1_start_x[CW-1], seg1_start_x});
			wy_s1  <= $signed({seg2_start_y[CW-1], seg2_start_y})
				- $signed({seg1_start_y[CW-1], seg1_start_y});

			p1x_s2 <= p1x_s1;
			p1y_s2 <= p1y_s1;
			d1x_s2 <= d1x_s1;
			d1y_s2 <= d1y_s1;
			ma_s2  <= d1x_s1 * d2y_s1;
			mb_s2  <= d1y_s1 * d2x_s1;
			mc_s2  <= wx_s1 * d2y_s1;
			md_s2  <= wy_s1 * d2x_s1;
			me_s2  <= wx_s1 * d1y_s1;
			mf_s2  <= wy_s1 * d1x_s1;

			p1x_s3   <= p1x_s2;
			p1y_s3   <= p1y_s2;
			d1x_s3   <= d1x_s2;
			d1y_s3   <= d1y_s2;
			cross_s3 <= XW'(ma_s2) - XW'(mb_s2);
			tn_s3    <= XW'(mc_s2) - XW'(md_s2);
			un_s3    <= XW'(me_s2) - XW'(mf_s2);

			p1x_s4 <= p1x_s3;
			p1y_s4 <= p1y_s3;
			d1x_s4 <= d1x_s3;
			d1y_s4 <= d1y_s3;
			tn_s4  <= tnn;
			den_s4 <= cabs[DW-1:0];
			flg_s4.parallel  <= (cross_s3 == '0);
			flg_s4.seg_cross <= c_cross;

			psl_x_s5 <= psl_x;
			psh_x_s5 <= psh_x;
			psl_y_s5 <= psl_y;
			psh_y_s5 <= psh_y;
			pdl_x_s5 <= pdl_x;
			pdh_x_s5 <= pdh_x;
			pdl_y_s5 <= pdl_y;
			pdh_y_s5 <= pdh_y;
			den_s5   <= den_s4;
			flg_s5   <= flg_s4;

			a_x_s6 <= (NW'(psh_x_s5) <<< HW) + NW'(psl_x_s5);
			b_x_s6 <= (NW'(pdh_x_s5) <<< HW) + NW'(pdl_x_s5);
			a_y_s6 <= (NW'(psh_y_s5) <<< HW) + NW'(psl_y_s5);
			b_y_s6 <= (NW'(pdh_y_s5) <<< HW) + NW'(pdl_y_s5);
			den_s6 <= den_s5;
			flg_s6 <= flg_s5;

			num_x_s7 <= a_x_s6 + b_x_s6;
			num_y_s7 <= a_y_s6 + b_y_s6;
			den_s7   <= den_s6;
			flg_s7   <= flg_s6;
		end
	end

endmodule

/* sv/sit_div.sv */
module sit_div #(
	parameter int NUM_W     = 52,
	parameter int DEN_W     = 34,
	parameter int FRAC_BITS = 8
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [NUM_W-1:0]      num,
	input  logic [DEN_W-1:0]             den,
	output logic [sit_pkg::DIV_QBITS:0]  quo,
	output logic                         neg,
	output logic                         ovf
);

	localparam int QB = sit_pkg::DIV_QBITS;
	localparam int TW = NUM_W + FRAC_BITS;
	localparam int NE = TW + QB;

	logic [NUM_W-1:0] mag_s0;
	logic             neg_s0;
	logic [DEN_W-1:0] den_s0;

	logic [DEN_W-1:0] rem_s [QB+1];
	logic [QB-1:0]    low_s [QB];
	logic [QB-1:0]    quo_s [QB+1];
	logic [DEN_W-1:0] den_s [QB+1];
	logic             neg_s [QB+1];
	logic             ovf_s [QB+1];

	logic [NE-1:0]    scaled;
	logic [TW-1:0]    top;
	logic             up;

	logic [QB:0]      rnd_quo_s;
	logic             rnd_neg_s;
	logic             rnd_ovf_s;

	assign scaled = NE'(mag_s0) << FRAC_BITS;
	assign top    = scaled[NE-1:QB];
	// round half away from zero on the magnitude
	assign up     = {1'b0, rem_s[QB], 1'b0} >= {2'b00, den_s[QB]};

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s0 <= num[NUM_W-1];
			mag_s0 <= num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
			den_s0 <= den;

			// quotient of 2^32 or more: saturates regardless of the rest
			ovf_s[0] <= top >= TW'(den_s0);
			rem_s[0] <= top[DEN_W-1:0];
			low_s[0] <= scaled[QB-1:0];
			quo_s[0] <= '0;
			den_s[0] <= den_s0;
			neg_s[0] <= neg_s0;

			rnd_quo_s <= {1'b0, quo_s[QB]} + (QB+1)'(up);
			rnd_neg_s <= neg_s[QB];
			rnd_ovf_s <= ovf_s[QB];
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [DEN_W:0] t;
		logic [DEN_W:0] d;
		logic           ge;

		assign t  = {rem_s[k], low_s[k][QB-1]};
		assign d  = t - {1'b0, den_s[k]};
		assign ge = t >= {1'b0, den_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? d[DEN_W-1:0] : t[DEN_W-1:0];
				quo_s[k+1] <= {quo_s[k][QB-2:0], ge};
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end

		if (k < QB - 1) begin : g_low
			always_ff @(posedge clk) begin
				if (en) begin
					low_s[k+1] <= {low_s[k][QB-2:0], 1'b0};
				end
			end
		end
	end

	assign quo = rnd_quo_s;
	assign neg = rnd_neg_s;
	assign ovf = rnd_ovf_s;

endmodule

/* sv/sit_back.sv */
module sit_back #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	output logic                           q_pop,
	input  logic signed [3*COORD_BITS+3:0] num_x,
	input  logic signed [3*COORD_BITS+3:0] num_y,
	input  logic [2*COORD_BITS+1:0]        den,
	input  sit_pkg::flags_t                flags,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic                           segments_cross,
	output logic                           lines_parallel,
	output logic signed [31:0]             meet_x,
	output logic signed [31:0]             meet_y,
	output logic                           point_saturated
);

	localparam int NW  = 3 * COORD_BITS + 4;
	localparam int DW  = 2 * COORD_BITS + 2;
	localparam int LAT = sit_pkg::DIV_LAT;
	localparam int QB  = sit_pkg::DIV_QBITS;

	logic                 en;
	logic                 vld_s [LAT];
	sit_pkg::flags_t      flg_s [LAT];
	logic [QB:0]          quo_x, quo_y;
	logic                 neg_x, neg_y, ovf_x, ovf_y;
	logic [32:0]          res_x, res_y;

	logic                 valid_q;
	logic                 cross_q, par_q, sat_q;
	logic [31:0]          mx_q, my_q;

	function automatic logic [32:0] clamp(input logic [QB:0] q, input logic n,
			input logic o);
		logic [31:0] lim;
		logic        sat;
		lim = n ? sit_pkg::MEET_MIN : sit_pkg::MEET_MAX;
		sat = o || (q > {1'b0, lim});
		if (sat) begin
			clamp = {1'b1, lim};
		end else begin
			clamp = {1'b0, n ? (32'd0 - q[31:0]) : q[31:0]};
		end
	endfunction

	assign en    = !(valid_q && result_stall);
	assign q_pop = en && !q_empty;

	sit_div #(
		.NUM_W     (NW),
		.DEN_W     (DW),
		.FRAC_BITS (FRAC_BITS)
	) u_div_x (
		.clk (clk),
		.en  (en),
		.num (num_x),
		.den (den),
		.quo (quo_x),
		.neg (neg_x),
		.ovf (ovf_x)
	);

	sit_div #(
		.NUM_W     (NW),
		.DEN_W     (DW),
		.FRAC_BITS (FRAC_BITS)
	) u_div_y (
		.clk (clk),
		.en  (en),
		.num (num_y),
		.den (den),
		.quo (quo_y),
		.neg (neg_y),
		.ovf (ovf_y)
	);

	assign res_x = clamp(quo_x, neg_x, ovf_x);
	assign res_y = clamp(quo_y, neg_y, ovf_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				vld_s[k] <= 1'b0;
			end
			valid_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= !q_empty;
			for (int k = 1; k < LAT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			valid_q <= vld_s[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flg_s[0] <= flags;
			for (int k = 1; k < LAT; k++) begin
				flg_s[k] <= flg_s[k-1];
			end
			// parallel: the divider ran on a zero divisor, drop its output
			par_q   <= flg_s[LAT-1].parallel;
			cross_q <= flg_s[LAT-1].seg_cross && !flg_s[LAT-1].parallel;
			sat_q   <= (res_x[32] || res_y[32]) && !flg_s[LAT-1].parallel;
			mx_q    <= flg_s[LAT-1].parallel ? 32'd0 : res_x[31:0];
			my_q    <= flg_s[LAT-1].parallel ? 32'd0 : res_y[31:0];
		end
	end

	assign result_valid    = valid_q;
	assign segments_cross  = cross_q;
	assign lines_parallel  = par_q;
	assign meet_x          = mx_q;
	assign meet_y          = my_q;
	assign point_saturated = sat_q;

endmodule

/* sv/segment_intersection_test.sv */
// Two-segment intersection test. Each request carries segments P1->P2 and
// Q1->Q2 as signed COORD_BITS-bit pixel coordinates and produces exactly one
// result: the meeting point of the two infinite lines in signed fixed point
// with FRAC_BITS fraction bits (rounded to nearest, halves away from zero,
// saturated to 32 bits with point_saturated set), segments_cross when the
// point lies on both segments endpoints included (exact test, t and u in
// [0,1]), and lines_parallel when the direction cross product is zero, in
// which case every other field reads zero. Collinear overlaps are reported
// as parallel. A new request is taken every clock while item_stall is low;
// it then passes through a 7-stage front (differences, products, cross
// product and sign fix, split multiplies for the numerators), a 4-entry
// queue, then two 35-stage dividers (two operand stages, 32 stages of one
// quotient bit each, one rounding stage), and the output register before
// result_valid. The front and the dividers stall independently; item_stall
// rises only when the queue is full and the front's last stage holds a
// request.
module segment_intersection_test #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic signed [COORD_BITS-1:0] seg1_start_x,
	input  logic signed [COORD_BITS-1:0] seg1_start_y,
	input  logic signed [COORD_BITS-1:0] seg1_end_x,
	input  logic signed [COORD_BITS-1:0] seg1_end_y,
	input  logic signed [COORD_BITS-1:0] seg2_start_x,
	input  logic signed [COORD_BITS-1:0] seg2_start_y,
	input  logic signed [COORD_BITS-1:0] seg2_end_x,
	input  logic signed [COORD_BITS-1:0] seg2_end_y,

	output logic                         result_valid,
	input  logic                         result_stall,
	output logic                         segments_cross,
	output logic                         lines_parallel,
	output logic signed [31:0]           meet_x,
	output logic signed [31:0]           meet_y,
	output logic                         point_saturated
);

	// numerator (start*|cross| + dir*tn) and divisor |cross| widths
	localparam int NW = 3 * COORD_BITS + 4;
	localparam int DW = 2 * COORD_BITS + 2;
	localparam int FW = $bits(sit_pkg::flags_t);
	localparam int QW = 2 * NW + DW + FW;

	// front -> queue
	logic                 f_push;
	logic signed [NW-1:0] f_num_x, f_num_y;
	logic [DW-1:0]        f_den;
	sit_pkg::flags_t      f_flags;
	logic [QW-1:0]        f_data;
	logic                 q_full;

	// queue -> back
	logic                 b_pop;
	logic [QW-1:0]        b_data;
	logic                 q_empty;
	logic signed [NW-1:0] b_num_x, b_num_y;
	logic [DW-1:0]        b_den;
	sit_pkg::flags_t      b_flags;

	// front: classify (parallel, crossing) and form the division operands
	sit_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.seg1_start_x (seg1_start_x),
		.seg1_start_y (seg1_start_y),
		.seg1_end_x   (seg1_end_x),
		.seg1_end_y   (seg1_end_y),
		.seg2_start_x (seg2_start_x),
		.seg2_start_y (seg2_start_y),
		.seg2_end_x   (seg2_end_x),
		.seg2_end_y   (seg2_end_y),
		.q_full       (q_full),
		.q_push       (f_push),
		.num_x        (f_num_x),
		.num_y        (f_num_y),
		.den          (f_den),
		.flags        (f_flags)
	);

	assign f_data = {f_num_x, f_num_y, f_den, f_flags};

	sit_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_data (f_data),
		.full      (q_full),
		.pop       (b_pop),
		.pop_data  (b_data),
		.empty     (q_empty)
	);

	assign {b_num_x, b_num_y, b_den, b_flags} = b_data;

	// back: two pipelined dividers, rounding, saturation, output register
	sit_back #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_pop           (b_pop),
		.num_x           (b_num_x),
		.num_y           (b_num_y),
		.den             (b_den),
		.flags           (b_flags),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.segments_cross  (segments_cross),
		.lines_parallel  (lines_parallel),
		.meet_x          (meet_x),
		.meet_y          (meet_y),
		.point_saturated (point_saturated)
	);

	// parallel result carries no point and no crossing
	a_parallel_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && lines_parallel |->
			!segments_cross && !point_saturated && meet_x == '0 && meet_y == '0)
		else $error("parallel result with nonzero point fields");

	// a clipped point sits on a rail in at least one coordinate
	a_sat_on_rail: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && point_saturated |->
			meet_x == sit_pkg::MEET_MAX || meet_x == sit_pkg::MEET_MIN ||
			meet_y == sit_pkg::MEET_MAX || meet_y == sit_pkg::MEET_MIN)
		else $error("saturation flagged but no coordinate at a limit");

endmodule

/* test/segment_intersection_test_tb.sv */
`timescale 1ns / 100ps

module segment_intersection_test_tb;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 8;

	// Upper bound on the whole run in cycles, with room for the long hold.
	localparam int CYCLE_LIMIT      = 400000;
	localparam int RANDOM_REQUESTS  = 950;
	// Receiver parks itself for a long while once this many results are in.
	localparam int HOLD_AT_RESULT   = 200;
	localparam int HOLD_CYCLES      = 300;
	// Sender drains the block completely before this random request.
	localparam int PAUSE_AT_REQUEST = 500;
	// Extra margin after the last result to catch stray results at the end.
	localparam int DRAIN_CYCLES     = 100;
	localparam int MAX_REPORTS      = 10;

	// Directed table columns: eight coordinates, a flag telling whether the
	// expected result is typed in, then the five result fields.
	localparam int N_DIRECTED = 18;
	localparam int COL_TYPED  = 8;
	localparam int COL_CROSS  = 9;
	localparam int COL_PAR    = 10;
	localparam int COL_X      = 11;
	localparam int COL_Y      = 12;
	localparam int COL_SAT    = 13;

	// Random request shapes.
	typedef enum int {
		REQ_ANY,
		REQ_NEAR_ORIGIN,
		REQ_PARALLEL,
		REQ_FAR_MEET,
		REQ_TINY_GRID
	} req_shape_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] s1x, s1y, e1x, e1y;
		logic signed [COORD_BITS-1:0] s2x, s2y, e2x, e2y;
	} seg_pair_t;

	typedef struct packed {
		logic        seg_cross;
		logic        parallel;
		logic [31:0] mx;
		logic [31:0] my;
		logic        clipped;
	} meet_t;

	logic                         clk;
	logic                         arst_n       = 1'b0;
	logic                         item_valid   = 1'b0;
	logic                         item_stall;
	logic signed [COORD_BITS-1:0] seg1_start_x = '0;
	logic signed [COORD_BITS-1:0] seg1_start_y = '0;
	logic signed [COORD_BITS-1:0] seg1_end_x   = '0;
	logic signed [COORD_BITS-1:0] seg1_end_y   = '0;
	logic signed [COORD_BITS-1:0] seg2_start_x = '0;
	logic signed [COORD_BITS-1:0] seg2_start_y = '0;
	logic signed [COORD_BITS-1:0] seg2_end_x   = '0;
	logic signed [COORD_BITS-1:0] seg2_end_y   = '0;
	logic                         result_valid;
	logic                         result_stall = 1'b0;
	logic                         segments_cross;
	logic                         lines_parallel;
	logic signed [31:0]           meet_x;
	logic signed [31:0]           meet_y;
	logic                         point_saturated;

	meet_t pending_meets[$];
	int    mismatch_count  = 0;
	int    results_seen    = 0;
	int    cycle_count     = 0;
	bit    sender_no_gaps  = 1'b0;
	bit    receiver_eager  = 1'b0;

	// Directed requests. Typed rows: degenerate and parallel cases, simple
	// crossings, a crossing exactly at (-1,-1), endpoint touch, both signs of
	// a half-LSB rounding, full-range corners, saturation both ways.
	// Untyped rows go through the predictor.
	int directed_tab [N_DIRECTED][14] = '{
		// all zero: zero-length segments
		'{0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 0, 0, 0},
		// first segment is a point
		'{5, 5, 5, 5, -7, 3, 9, -2, 1, 0, 1, 0, 0, 0},
		// distinct horizontal parallels
		'{0, 0, 10, 0, 0, 5, 10, 5, 1, 0, 1, 0, 0, 0},
		// collinear and overlapping
		'{0, 0, 10, 10, 5, 5, 15, 15, 1, 0, 1, 0, 0, 0},
		// every coordinate at its top
		'{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1, 0, 1, 0, 0, 0},
		// every coordinate at its bottom
		'{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
		  1, 0, 1, 0, 0, 0},
		// plain X, meets at (1,1)
		'{0, 0, 2, 2, 0, 2, 2, 0, 1, 1, 0, 256, 256, 0},
		// meets at (-1,-1), the old sentinel point
		'{-2, -2, 0, 0, -2, 0, 0, -2, 1, 1, 0, -256, -256, 0},
		// lines meet at (10,10), beyond both segments
		'{0, 0, 1, 1, 10, 0, 10, 1, 1, 0, 0, 2560, 2560, 0},
		// endpoint of one lies on the other's start
		'{0, 0, 4, 0, 4, 0, 4, 4, 1, 1, 0, 1024, 0, 0},
		// x = +1/512: half an LSB rounds up
		'{0, 0, 1, 0, 0, -1, 1, 511, 1, 1, 0, 1, 0, 0},
		// x = -1/512: half an LSB rounds away from zero
		'{0, 0, -1, 0, 0, -1, -1, 511, 1, 1, 0, -1, 0, 0},
		// diagonals across the whole coordinate range
		'{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768,
		  1, 1, 0, -128, -128, 0},
		// nearly parallel, meet far toward negative infinity
		'{0, 0, 32767, 32766, 0, -100, 32766, 32665,
		  1, 0, 0, int'(sit_pkg::MEET_MIN), int'(sit_pkg::MEET_MIN), 1},
		// nearly parallel, meet far toward positive infinity
		'{0, 0, -32767, -32766, 0, 100, -32766, -32665,
		  1, 0, 0, int'(sit_pkg::MEET_MAX), int'(sit_pkg::MEET_MAX), 1},
		'{21845, -21846, -21846, 21845, 12345, -4321, -30000, 29999,
		  0, 0, 0, 0, 0, 0},
		'{3, 7, -11, 2, -5, -9, 8, 13, 0, 0, 0, 0, 0, 0},
		'{-1, -3, 7, 5, 2, -6, -4, 9, 0, 0, 0, 0, 0, 0}
	};

	segment_intersection_test #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.seg1_start_x   (seg1_start_x),
		.seg1_start_y   (seg1_start_y),
		.seg1_end_x     (seg1_end_x),
		.seg1_end_y     (seg1_end_y),
		.seg2_start_x   (seg2_start_x),
		.seg2_start_y   (seg2_start_y),
		.seg2_end_x     (seg2_end_x),
		.seg2_end_y     (seg2_end_y),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.segments_cross (segments_cross),
		.lines_parallel (lines_parallel),
		.meet_x         (meet_x),
		.meet_y         (meet_y),
		.point_saturated(point_saturated)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop if the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// One coordinate of the meeting point: (start*cross + dir*tn) / cross,
	// scaled by 2^FRAC_BITS, rounded half away from zero, clipped to 32 bits.
	// cross is positive here.
	function automatic logic [31:0] scaled_coord(longint start, longint dir,
			longint tn, longint crs, output bit clipped);
		logic signed [127:0] s_w, d_w, c_w, t_w, num;
		logic [127:0] mag, quo, rem, den, limit;
		bit neg;
		s_w = 128'(start);
		d_w = 128'(dir);
		c_w = 128'(crs);
		t_w = 128'(tn);
		num = s_w * c_w + d_w * t_w;
		neg = num[127];
		mag = neg ? -num : num;
		mag = mag << FRAC_BITS;
		den = c_w;
		quo = mag / den;
		rem = mag % den;
		if (rem >= den - rem)
			quo = quo + 128'd1;
		limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
		clipped = (quo > limit);
		if (clipped)
			return neg ? sit_pkg::MEET_MIN : sit_pkg::MEET_MAX;
		return neg ? -quo[31:0] : quo[31:0];
	endfunction

	// Expected result of one request.
	function automatic meet_t predict_meet(seg_pair_t r);
		longint d1x, d1y, d2x, d2y, wx, wy, crs, tn, un;
		bit clip_x, clip_y;
		meet_t res;
		res = '0;
		d1x = longint'(r.e1x) - longint'(r.s1x);
		d1y = longint'(r.e1y) - longint'(r.s1y);
		d2x = longint'(r.e2x) - longint'(r.s2x);
		d2y = longint'(r.e2y) - longint'(r.s2y);
		wx  = longint'(r.s2x) - longint'(r.s1x);
		wy  = longint'(r.s2y) - longint'(r.s1y);
		crs = d1x * d2y - d1y * d2x;
		if (crs == 0) begin
			res.parallel = 1'b1;
			return res;
		end
		tn = wx * d2y - wy * d2x;
		un = wx * d1y - wy * d1x;
		// normalize so the divisor is positive
		if (crs < 0) begin
			crs = -crs;
			tn  = -tn;
			un  = -un;
		end
		res.seg_cross = (tn >= 0 && tn <= crs && un >= 0 && un <= crs);
		res.mx        = scaled_coord(longint'(r.s1x), d1x, tn, crs, clip_x);
		res.my        = scaled_coord(longint'(r.s1y), d1y, tn, crs, clip_y);
		res.clipped   = clip_x | clip_y;
		return res;
	endfunction

	function automatic int sym(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// Random request. Mostly full-range noise and small coordinates, plus
	// shapes that hit parallel lines, far-away meets and exact touches.
	function automatic seg_pair_t make_request();
		seg_pair_t r;
		req_shape_t shape;
		int pick, px, py, qx, qy, dx, dy, k;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			shape = REQ_ANY;
		else if (pick < 75)
			shape = REQ_NEAR_ORIGIN;
		else if (pick < 85)
			shape = REQ_PARALLEL;
		else if (pick < 95)
			shape = REQ_FAR_MEET;
		else
			shape = REQ_TINY_GRID;
		case (shape)
			REQ_ANY: begin
				r = seg_pair_t'({$urandom(), $urandom(), $urandom(), $urandom()});
			end
			REQ_NEAR_ORIGIN, REQ_TINY_GRID: begin
				k = (shape == REQ_TINY_GRID) ? 4 : 64;
				r.s1x = COORD_BITS'(sym(k)); r.s1y = COORD_BITS'(sym(k));
				r.e1x = COORD_BITS'(sym(k)); r.e1y = COORD_BITS'(sym(k));
				r.s2x = COORD_BITS'(sym(k)); r.s2y = COORD_BITS'(sym(k));
				r.e2x = COORD_BITS'(sym(k)); r.e2y = COORD_BITS'(sym(k));
			end
			REQ_PARALLEL: begin
				dx = sym(200); dy = sym(200); k = sym(3);
				px = sym(1000); py = sym(1000); qx = sym(1000); qy = sym(1000);
				r.s1x = COORD_BITS'(px); r.s1y = COORD_BITS'(py);
				r.e1x = COORD_BITS'(px + dx); r.e1y = COORD_BITS'(py + dy);
				r.s2x = COORD_BITS'(qx); r.s2y = COORD_BITS'(qy);
				r.e2x = COORD_BITS'(qx + k * dx); r.e2y = COORD_BITS'(qy + k * dy);
			end
			default: begin
				// directions differ by at most one pixel: meet can be very far out
				dx = sym(15000); dy = sym(15000);
				px = sym(1000); py = sym(1000); qx = px + sym(50); qy = py + sym(50);
				r.s1x = COORD_BITS'(px); r.s1y = COORD_BITS'(py);
				r.e1x = COORD_BITS'(px + dx); r.e1y = COORD_BITS'(py + dy);
				r.s2x = COORD_BITS'(qx); r.s2y = COORD_BITS'(qy);
				r.e2x = COORD_BITS'(qx + dx + sym(1));
				r.e2y = COORD_BITS'(qy + dy + sym(1));
			end
		endcase
		return r;
	endfunction

	// Offer one request after a random gap; wait for it to be taken, then
	// queue its expected result. Valid is only lowered when a gap follows, so
	// back-to-back requests keep it high.
	task automatic offer_request(seg_pair_t r, bit typed, meet_t want);
		int gap;
		gap = sender_no_gaps ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid   <= 1'b1;
		seg1_start_x <= r.s1x;
		seg1_start_y <= r.s1y;
		seg1_end_x   <= r.e1x;
		seg1_end_y   <= r.e1y;
		seg2_start_x <= r.s2x;
		seg2_start_y <= r.s2y;
		seg2_end_x   <= r.e2x;
		seg2_end_y   <= r.e2y;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		pending_meets.push_back(typed ? want : predict_meet(r));
	endtask

	task automatic check_meet(meet_t got);
		meet_t want;
		if (pending_meets.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("result %0d with no request pending: cross=%0b par=%0b x=%0d y=%0d sat=%0b",
					results_seen, got.seg_cross, got.parallel,
					$signed(got.mx), $signed(got.my), got.clipped);
		end else begin
			want = pending_meets.pop_front();
			if (got.seg_cross !== want.seg_cross || got.parallel !== want.parallel ||
					got.mx !== want.mx || got.my !== want.my ||
					got.clipped !== want.clipped) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("result %0d: want cross=%0b par=%0b x=%0d y=%0d sat=%0b, got cross=%0b par=%0b x=%0d y=%0d sat=%0b",
						results_seen, want.seg_cross, want.parallel,
						$signed(want.mx), $signed(want.my), want.clipped,
						got.seg_cross, got.parallel,
						$signed(got.mx), $signed(got.my), got.clipped);
			end
		end
	endtask

	// Result side: random stall before each result, stretches with no stall,
	// and one long hold that backs the pipe up into the request port.
	initial begin
		int hold;
		meet_t got;
		wait (arst_n === 1'b1);
		forever begin
			if (results_seen % 40 == 0)
				receiver_eager = ($urandom_range(0, 3) == 0);
			if (results_seen == HOLD_AT_RESULT)
				hold = HOLD_CYCLES;
			else
				hold = receiver_eager ? 0 : $urandom_range(0, 7);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!result_valid)
				@(posedge clk);
			got.seg_cross = segments_cross;
			got.parallel  = lines_parallel;
			got.mx        = meet_x;
			got.my        = meet_y;
			got.clipped   = point_saturated;
			check_meet(got);
			results_seen++;
		end
	end

	// Request side and end of run.
	initial begin
		seg_pair_t r;
		meet_t want;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			for (int c = 0; c < 8; c++)
				r[COORD_BITS*(7-c) +: COORD_BITS] = directed_tab[i][c][COORD_BITS-1:0];
			want.seg_cross = directed_tab[i][COL_CROSS][0];
			want.parallel  = directed_tab[i][COL_PAR][0];
			want.mx        = directed_tab[i][COL_X];
			want.my        = directed_tab[i][COL_Y];
			want.clipped   = directed_tab[i][COL_SAT][0];
			offer_request(r, directed_tab[i][COL_TYPED][0], want);
		end

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i % 50 == 0)
				sender_no_gaps = ($urandom_range(0, 3) == 0);
			if (i == PAUSE_AT_REQUEST) begin
				// let the block empty out completely before going on
				item_valid <= 1'b0;
				do
					@(posedge clk);
				while (pending_meets.size() != 0);
			end
			offer_request(make_request(), 1'b0, '0);
		end
		item_valid <= 1'b0;

		while (pending_meets.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* filelist.f */
sv/sit_pkg.sv
sv/sit_queue.sv
sv/sit_front.sv
sv/sit_div.sv
sv/sit_back.sv
sv/segment_intersection_test.sv
test/segment_intersection_test_tb.sv
